// ----- src/pip_pkg.sv -----
// Shared constants, types and codes for the point-in-polygon classifier.
`timescale 1ns / 1ps
package pip_pkg;

  localparam int COORD_W   = 32;
  localparam int VTX_DEPTH = 256;
  localparam int VTX_AW    = $clog2(VTX_DEPTH);
  localparam int CNT_W     = VTX_AW + 1;
  localparam int THR_W     = 31;
  localparam int MAG_W     = COORD_W;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int DIV_STEPS = MAG_W;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_VCOUNT = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OUTSIDE = 2'd0,
    STATUS_INSIDE  = 2'd1,
    STATUS_EDGE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  // One polygon edge together with the query point.
  typedef struct packed {
    logic                      vld;
    logic                      last;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic signed [COORD_W-1:0] xx;
    logic signed [COORD_W-1:0] yy;
  } edge_t;

  // Beat handed from cell to cell along the divider chain.
  typedef struct packed {
    logic                      vld;
    logic                      last;
    logic                      hit;
    logic                      inc;
    logic                      div;
    logic                      neg;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] xx;
    logic [MAG_W-1:0]          rem;
    logic [MAG_W-1:0]          dvd;
    logic [MAG_W-1:0]          dsr;
    logic [MAG_W-1:0]          quo;
  } div_beat_t;

endpackage

// ----- src/pip_if.sv -----
// Stream interfaces for query/load beats and result beats.
`timescale 1ns / 1ps
interface pip_in_if import pip_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [VTX_AW-1:0]         vertex_index;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;

  modport source (output valid, opcode, vertex_index, x_coord, y_coord, input ready);
  modport sink   (input valid, opcode, vertex_index, x_coord, y_coord, output ready);
endinterface

interface pip_out_if import pip_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [CNT_W-1:0] crossing_count;

  modport source (output valid, status, crossing_count, input ready);
  modport sink   (input valid, status, crossing_count, output ready);
endinterface

// ----- src/point_in_polygon_test_top.sv -----
// One query at a time; the vertex read port streams one edge per cycle into a 32-cell
//   division chain, and the next query is taken once the result register has been loaded.
// Loads are accepted back to back while idle; a query with zero vertices goes straight to
//   HOLD, which loads the result register.
// Reset: synchronous, active low; clears control and configuration, not the vertex store.
`timescale 1ns / 1ps
module point_in_polygon_test_top import pip_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  pip_in_if.sink              in_bus,
  pip_out_if.source           out_bus,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [CFG_DW-1:0]   cfg_pwdata,
  output logic [CFG_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  // ---------------- configuration registers ----------------
  logic             cfg_wr;
  logic             reg_sel;
  logic [CNT_W-1:0] vcount_r;
  logic [THR_W-1:0] thresh_r;
  logic [CNT_W-1:0] n_edges;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[CFG_AW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      thresh_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_VCOUNT: vcount_r <= cfg_pwdata[CNT_W-1:0];
        REG_THRESH: thresh_r <= cfg_pwdata[THR_W-1:0];
        default:    vcount_r <= vcount_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_VCOUNT: cfg_prdata = {{(CFG_DW-CNT_W){1'b0}}, vcount_r};
      REG_THRESH: cfg_prdata = {{(CFG_DW-THR_W){1'b0}}, thresh_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // clamp the vertex count to the store depth
  assign n_edges = (vcount_r > CNT_W'(VTX_DEPTH)) ? CNT_W'(VTX_DEPTH) : vcount_r;

  // ---------------- sequencer ----------------
  state_t           state_r, state_nxt;
  logic             in_acc, is_query, rd_en, out_load;
  logic             tail_done;
  logic [CNT_W-1:0] k_r;
  logic [VTX_AW-1:0] rd_addr;
  logic signed [COORD_W-1:0] qx_r, qy_r;

  assign in_acc   = in_bus.valid & in_bus.ready;
  assign is_query = in_bus.opcode == OP_QUERY;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && is_query) state_nxt = (n_edges == '0) ? ST_HOLD : ST_RUN;
      ST_RUN:   if (k_r == n_edges) state_nxt = ST_DRAIN;
      ST_DRAIN: if (tail_done) state_nxt = ST_HOLD;
      ST_HOLD:  if (!out_bus.valid || out_bus.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_bus.ready = 1'b0;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: in_bus.ready = 1'b1;
      ST_RUN:  rd_en = 1'b1;
      ST_HOLD: out_load = !out_bus.valid || out_bus.ready;
      default: in_bus.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        k_r <= '0;
      end else if (rd_en) begin
        k_r <= k_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_query) begin
      qx_r <= in_bus.x_coord;
      qy_r <= in_bus.y_coord;
    end
  end

  // the read past the last vertex wraps to vertex zero to close the polygon
  assign rd_addr = (k_r == n_edges) ? '0 : k_r[VTX_AW-1:0];

  // ---------------- vertex store ----------------
  logic signed [COORD_W-1:0] rd_x_r, rd_y_r;

  pip_vertex_mem u_mem (
    .clk     (clk),
    .wr_en   (in_acc && !is_query),
    .wr_addr (in_bus.vertex_index),
    .wr_x    (in_bus.x_coord),
    .wr_y    (in_bus.y_coord),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_x_r  (rd_x_r),
    .rd_y_r  (rd_y_r)
  );

  // ---------------- edge assembly ----------------
  logic rd_vld_r, rd_first_r, rd_last_r;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  edge_t edge_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= k_r == '0;
    rd_last_r  <= k_r == n_edges;
    if (rd_vld_r) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
    end
  end

  // an edge forms once its start vertex has been seen
  always_comb begin
    edge_cur.vld  = rd_vld_r && !rd_first_r;
    edge_cur.last = rd_last_r;
    edge_cur.x1   = prev_x_r;
    edge_cur.y1   = prev_y_r;
    edge_cur.x2   = rd_x_r;
    edge_cur.y2   = rd_y_r;
    edge_cur.xx   = qx_r;
    edge_cur.yy   = qy_r;
  end

  // ---------------- classifier front and divider chain ----------------
  div_beat_t link [DIV_STEPS+1];

  pip_edge_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .edge_in (edge_cur),
    .beat_r  (link[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    pip_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .beat_in (link[g]),
      .beat_r  (link[g+1])
    );
  end

  // ---------------- intersection and accumulate ----------------
  div_beat_t tail;
  logic signed [COORD_W+1:0] q_signed;
  logic signed [COORD_W+1:0] xi_nxt;

  logic                      fin_vld_r, fin_last_r, fin_hit_r, fin_inc_r, fin_div_r;
  logic signed [COORD_W+1:0] fin_xi_r;
  logic signed [COORD_W+1:0] fin_xx_r;
  logic signed [COORD_W+2:0] x_gap;
  logic [COORD_W+2:0]        x_gap_mag;
  logic                      near, edge_hit, edge_inc;

  logic             hit_acc_r;
  logic [CNT_W-1:0] cross_acc_r;

  assign tail     = link[DIV_STEPS];
  assign q_signed = tail.neg ? -$signed({2'b00, tail.quo}) : $signed({2'b00, tail.quo});
  assign xi_nxt   = q_signed + {{2{tail.x1[COORD_W-1]}}, tail.x1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else begin
      fin_vld_r <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    fin_last_r <= tail.last;
    fin_hit_r  <= tail.hit;
    fin_inc_r  <= tail.inc;
    fin_div_r  <= tail.div;
    fin_xi_r   <= xi_nxt;
    fin_xx_r   <= {{2{tail.xx[COORD_W-1]}}, tail.xx};
  end

  assign x_gap     = {fin_xx_r[COORD_W+1], fin_xx_r} - {fin_xi_r[COORD_W+1], fin_xi_r};
  assign x_gap_mag = x_gap[COORD_W+2] ? (COORD_W+3)'(0) - x_gap : x_gap;
  assign near      = x_gap_mag < {{(COORD_W+3-THR_W){1'b0}}, thresh_r};
  assign edge_hit  = fin_hit_r || (fin_div_r && near);
  assign edge_inc  = fin_inc_r || (fin_div_r && !near && (fin_xx_r < fin_xi_r));
  assign tail_done = fin_vld_r && fin_last_r;

  // clear on query start; the last edge is in the accumulators when HOLD is entered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_acc_r   <= 1'b0;
      cross_acc_r <= '0;
    end else if (in_acc && is_query) begin
      hit_acc_r   <= 1'b0;
      cross_acc_r <= '0;
    end else if (fin_vld_r) begin
      hit_acc_r   <= hit_acc_r | edge_hit;
      cross_acc_r <= cross_acc_r + CNT_W'(edge_inc);
    end
  end

  // ---------------- result register ----------------
  logic             out_vld_r;
  status_t          out_status_r;
  logic [CNT_W-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (hit_acc_r) begin
        out_status_r <= STATUS_EDGE;
        out_count_r  <= '0;
      end else begin
        out_status_r <= cross_acc_r[0] ? STATUS_INSIDE : STATUS_OUTSIDE;
        out_count_r  <= cross_acc_r;
      end
    end
  end

  assign out_bus.valid          = out_vld_r;
  assign out_bus.status         = out_status_r;
  assign out_bus.crossing_count = out_count_r;

endmodule

// ----- src/pip_vertex_mem.sv -----
// Vertex store: one write port, one registered read port.
`timescale 1ns / 1ps
module pip_vertex_mem import pip_pkg::*; (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [VTX_AW-1:0]         wr_addr,
  input  logic signed [COORD_W-1:0] wr_x,
  input  logic signed [COORD_W-1:0] wr_y,
  input  logic                      rd_en,
  input  logic [VTX_AW-1:0]         rd_addr,
  output logic signed [COORD_W-1:0] rd_x_r,
  output logic signed [COORD_W-1:0] rd_y_r
);

  logic [2*COORD_W-1:0] mem_r [VTX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_x, wr_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x_r <= mem_r[rd_addr][2*COORD_W-1:COORD_W];
      rd_y_r <= mem_r[rd_addr][COORD_W-1:0];
    end
  end

endmodule

// ----- src/pip_edge_front.sv -----
// Edge classification and magnitude product ahead of the divider chain.
`timescale 1ns / 1ps
module pip_edge_front import pip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  edge_t     edge_in,
  output div_beat_t beat_r
);

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [COORD_W:0] v);
    logic signed [COORD_W:0] t;
    t = v[COORD_W] ? -v : v;
    return t[MAG_W-1:0];
  endfunction

  logic signed [COORD_W:0] a_diff, b_diff, c_diff;
  logic above, below, skip, hit, inc, div;

  logic                      s1_vld_r, s1_last_r, s1_hit_r, s1_inc_r, s1_div_r, s1_neg_r;
  logic signed [COORD_W-1:0] s1_x1_r, s1_xx_r;
  logic [MAG_W-1:0]          s1_ma_r, s1_mb_r, s1_mc_r;
  logic [PROD_W-1:0]         prod;

  assign a_diff = {edge_in.yy[COORD_W-1], edge_in.yy} - {edge_in.y1[COORD_W-1], edge_in.y1};
  assign b_diff = {edge_in.x2[COORD_W-1], edge_in.x2} - {edge_in.x1[COORD_W-1], edge_in.x1};
  assign c_diff = {edge_in.y2[COORD_W-1], edge_in.y2} - {edge_in.y1[COORD_W-1], edge_in.y1};

  always_comb begin
    above = (edge_in.yy <= edge_in.y1) && (edge_in.yy < edge_in.y2);
    below = (edge_in.yy >= edge_in.y1) && (edge_in.yy > edge_in.y2);
    skip  = above || below;
    hit   = 1'b0;
    inc   = 1'b0;
    div   = 1'b0;
    if (!skip) begin
      if (edge_in.yy == edge_in.y2) begin
        if (edge_in.y1 == edge_in.y2) begin
          hit = !((edge_in.xx < edge_in.x1 && edge_in.xx < edge_in.x2) ||
                  (edge_in.xx > edge_in.x1 && edge_in.xx > edge_in.x2));
        end else if (edge_in.xx == edge_in.x2) begin
          hit = 1'b1;
        end else begin
          inc = edge_in.x2 > edge_in.xx;
        end
      end else begin
        // point lies strictly between the edge's y ends
        div = (edge_in.xx <= edge_in.x1) || (edge_in.xx <= edge_in.x2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= edge_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= edge_in.last;
    s1_hit_r  <= hit;
    s1_inc_r  <= inc;
    s1_div_r  <= div;
    s1_neg_r  <= (b_diff != '0) && (a_diff[COORD_W] ^ b_diff[COORD_W] ^ c_diff[COORD_W]);
    s1_x1_r   <= edge_in.x1;
    s1_xx_r   <= edge_in.xx;
    s1_ma_r   <= mag_of(a_diff);
    s1_mb_r   <= mag_of(b_diff);
    s1_mc_r   <= mag_of(c_diff);
  end

  assign prod = s1_ma_r * s1_mb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else begin
      beat_r.vld <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    beat_r.last <= s1_last_r;
    beat_r.hit  <= s1_hit_r;
    beat_r.inc  <= s1_inc_r;
    beat_r.div  <= s1_div_r;
    beat_r.neg  <= s1_neg_r;
    beat_r.x1   <= s1_x1_r;
    beat_r.xx   <= s1_xx_r;
    beat_r.rem  <= prod[PROD_W-1:MAG_W];
    beat_r.dvd  <= prod[MAG_W-1:0];
    beat_r.dsr  <= s1_mc_r;
    beat_r.quo  <= '0;
  end

endmodule

// ----- src/pip_div_cell.sv -----
// One restoring-division step; cells are chained to form the quotient.
`timescale 1ns / 1ps
module pip_div_cell import pip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  div_beat_t beat_in,
  output div_beat_t beat_r
);

  logic [MAG_W:0] trial, diff;
  logic           ge;
  div_beat_t      beat_nxt;

  assign trial = {beat_in.rem, beat_in.dvd[MAG_W-1]};
  assign diff  = trial - {1'b0, beat_in.dsr};
  assign ge    = trial >= {1'b0, beat_in.dsr};

  always_comb begin
    beat_nxt     = beat_in;
    beat_nxt.rem = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
    beat_nxt.dvd = {beat_in.dvd[MAG_W-2:0], 1'b0};
    beat_nxt.quo = {beat_in.quo[MAG_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else begin
      beat_r.vld <= beat_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    beat_r.last <= beat_nxt.last;
    beat_r.hit  <= beat_nxt.hit;
    beat_r.inc  <= beat_nxt.inc;
    beat_r.div  <= beat_nxt.div;
    beat_r.neg  <= beat_nxt.neg;
    beat_r.x1   <= beat_nxt.x1;
    beat_r.xx   <= beat_nxt.xx;
    beat_r.rem  <= beat_nxt.rem;
    beat_r.dvd  <= beat_nxt.dvd;
    beat_r.dsr  <= beat_nxt.dsr;
    beat_r.quo  <= beat_nxt.quo;
  end

endmodule

// ----- src/pip_checker.sv -----
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
module pip_checker import pip_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_status,
  input logic [CNT_W-1:0] out_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("illegal status code");

  a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_EDGE |-> out_count == '0)
    else $error("boundary result with nonzero count");

  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_EDGE |-> (out_status == STATUS_INSIDE) == out_count[0])
    else $error("inside flag disagrees with crossing parity");

endmodule

bind point_in_polygon_test_top pip_checker u_pip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_status (out_bus.status),
  .out_count  (out_bus.crossing_count)
);
